FILE: src/tfd_pkg.sv
// Shared types, constants and codes of the tape file deframer.
package tfd_pkg;

  localparam int HEADER_LEN    = 9;
  localparam int HDR_AW        = $clog2(HEADER_LEN);
  localparam int NAME_CAPACITY = 17;
  localparam int MAX_RESULTS   = 4;
  localparam int RES_IDX_W     = $clog2(MAX_RESULTS);
  localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);
  localparam int NUM_CAND      = 8;

  localparam logic [7:0] SYNC_BYTE  = 8'h16;
  localparam logic [7:0] SYNC_END   = 8'h24;
  localparam logic [7:0] TYPE_BASIC = 8'h00;
  localparam logic [7:0] TYPE_DATA  = 8'h80;
  localparam logic [7:0] NAME_END   = 8'h00;

  localparam logic [4:0] SEC_COUNT_MAX = 5'd31;
  localparam logic [4:0] SCOUT_MAX     = 5'd31;
  localparam logic [3:0] RUN_MAX       = 4'd15;

  localparam logic [1:0] CFG_MIN_SYNC_RUN    = 2'd0;
  localparam logic [1:0] CFG_STRAY_RUN_LIMIT = 2'd1;
  localparam logic [1:0] CFG_BAD_RUN_LIMIT   = 2'd2;

  localparam logic [4:0] MIN_SYNC_RUN_RST    = 5'd3;
  localparam logic [3:0] STRAY_RUN_LIMIT_RST = 4'd8;
  localparam logic [3:0] BAD_RUN_LIMIT_RST   = 4'd4;

  typedef enum logic [2:0] {
    SEC_SYNC   = 3'b001,
    SEC_HEADER = 3'b010,
    SEC_NAME   = 3'b100
  } section_t;

  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_NAME      = 3'd1,
    KIND_START     = 3'd2,
    KIND_DONE      = 3'd3,
    KIND_TRUNCATED = 3'd4,
    KIND_HDR_REJ   = 3'd5,
    KIND_NAME_REJ  = 3'd6
  } kind_t;

  typedef struct packed {
    logic [4:0] min_sync_run;
    logic [3:0] stray_run_limit;
    logic [3:0] bad_run_limit;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] byte_value;
    logic       slow_mode;
    logic       sync_flag;
    logic       parity_flag;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] address;
    logic [16:0] count;
    logic [16:0] sync_error_count;
    logic [16:0] parity_error_count;
    logic        autorun;
    logic        basic;
    logic        file_slow;
  } result_t;

  typedef struct packed {
    logic                 load;
    logic [RES_CNT_W-1:0] n;
  } load_ctl_t;

endpackage

FILE: src/tfd_core.sv
// Input register, deframer state and single-pass result generation.
module tfd_core (
  input  logic                clk,
  input  logic                rst,
  input  tfd_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  tfd_pkg::in_item_t   in_item,
  input  logic                out_free,
  output tfd_pkg::load_ctl_t  ctl,
  output tfd_pkg::result_t    res [tfd_pkg::MAX_RESULTS]
);

  logic               in_full;
  tfd_pkg::in_item_t  item;
  logic               take;

  tfd_pkg::section_t  section, section_next;
  logic [4:0]         section_count, section_count_next;
  logic [7:0]         header_store [tfd_pkg::HEADER_LEN];
  logic [3:0]         stray_run, stray_run_next;
  logic [3:0]         bad_run, bad_run_next;
  logic               mode_slow, mode_slow_next;
  logic [4:0]         scout_se, scout_se_next;
  logic [4:0]         scout_pe, scout_pe_next;
  logic               pay_active, pay_active_next;
  logic [16:0]        pay_offset, pay_offset_next;
  logic [16:0]        pay_length, pay_length_next;
  logic [15:0]        pay_start, pay_start_next;
  logic [16:0]        pay_se, pay_se_next;
  logic [16:0]        pay_pe, pay_pe_next;

  logic                        hdr_we;
  logic [tfd_pkg::HDR_AW-1:0]  hdr_wa;
  logic                        do_clear;
  logic [16:0]                 missing;
  logic [15:0]                 hdr_end;
  logic [15:0]                 hdr_start;
  logic [16:0]                 file_len;
  tfd_pkg::result_t            cand [tfd_pkg::NUM_CAND];
  logic [tfd_pkg::NUM_CAND-1:0] cand_en;
  logic [tfd_pkg::RES_CNT_W-1:0] res_n;

  assign take     = in_full && out_free;
  assign in_ready = !in_full || out_free;
  assign missing  = (pay_length >= pay_offset) ? (pay_length - pay_offset) : 17'd0;
  assign hdr_end   = {header_store[4], header_store[5]};
  assign hdr_start = {header_store[6], header_store[7]};
  assign file_len  = {1'b0, 16'(hdr_end - hdr_start)} + 17'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (take) begin
      in_full <= 1'b0;
    end
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

  always_comb begin
    section_next       = section;
    section_count_next = section_count;
    stray_run_next     = stray_run;
    bad_run_next       = bad_run;
    mode_slow_next     = mode_slow;
    scout_se_next      = scout_se;
    scout_pe_next      = scout_pe;
    pay_active_next    = pay_active;
    pay_offset_next    = pay_offset;
    pay_length_next    = pay_length;
    pay_start_next     = pay_start;
    pay_se_next        = pay_se;
    pay_pe_next        = pay_pe;
    hdr_we             = 1'b0;
    hdr_wa             = section_count[tfd_pkg::HDR_AW-1:0];
    do_clear           = 1'b0;
    cand_en            = '0;
    for (int i = 0; i < tfd_pkg::NUM_CAND; i++) begin
      cand[i] = '0;
    end

    if (take) begin
      // truncate on flush or on a mode change while busy
      if (item.cmd || ((mode_slow != item.slow_mode) &&
                       (section != tfd_pkg::SEC_SYNC || pay_active))) begin
        do_clear = 1'b1;
        if (pay_active) begin
          cand_en[0]                 = 1'b1;
          cand[0].kind               = tfd_pkg::KIND_TRUNCATED;
          cand[0].count              = missing;
          cand[0].sync_error_count   = 17'(pay_se + missing);
          cand[0].parity_error_count = 17'(pay_pe + missing);
        end
      end
      if (do_clear) begin
        section_next       = tfd_pkg::SEC_SYNC;
        section_count_next = '0;
        stray_run_next     = tfd_pkg::RUN_MAX;
        bad_run_next       = tfd_pkg::RUN_MAX;
        mode_slow_next     = 1'b0;
        scout_se_next      = '0;
        scout_pe_next      = '0;
        pay_active_next    = 1'b0;
        pay_offset_next    = '0;
        pay_length_next    = '0;
        pay_start_next     = '0;
        pay_se_next        = '0;
        pay_pe_next        = '0;
      end

      if (!item.cmd) begin
        mode_slow_next = item.slow_mode;

        if (pay_active_next) begin
          cand_en[1]        = 1'b1;
          cand[1].kind      = tfd_pkg::KIND_PAYLOAD;
          cand[1].data_byte = item.byte_value;
          cand[1].address   = 16'(pay_start_next + pay_offset_next[15:0]);
          pay_offset_next   = 17'(pay_offset_next + 17'd1);
          pay_se_next       = 17'(pay_se_next + {16'd0, item.sync_flag});
          pay_pe_next       = 17'(pay_pe_next +
                                  {16'd0, item.parity_flag && !item.sync_flag});
          if (pay_offset_next == pay_length_next) begin
            cand_en[2]                 = 1'b1;
            cand[2].kind               = tfd_pkg::KIND_DONE;
            cand[2].sync_error_count   = pay_se_next;
            cand[2].parity_error_count = pay_pe_next;
            pay_active_next            = 1'b0;
          end
        end

        if (item.byte_value != tfd_pkg::SYNC_BYTE) begin
          if (stray_run_next < tfd_pkg::RUN_MAX) stray_run_next = stray_run_next + 4'd1;
        end else begin
          stray_run_next = '0;
        end
        if (item.sync_flag || item.parity_flag) begin
          if (bad_run_next < tfd_pkg::RUN_MAX) bad_run_next = bad_run_next + 4'd1;
        end else begin
          bad_run_next = '0;
        end

        case (section_next)
          tfd_pkg::SEC_HEADER: begin
            if (section_count_next < 5'(tfd_pkg::HEADER_LEN)) begin
              hdr_we = 1'b1;
              hdr_wa = section_count_next[tfd_pkg::HDR_AW-1:0];
            end
            section_count_next = section_count_next + 5'd1;
            if (item.sync_flag && scout_se_next < tfd_pkg::SCOUT_MAX)
              scout_se_next = scout_se_next + 5'd1;
            if (item.parity_flag && !item.sync_flag && scout_pe_next < tfd_pkg::SCOUT_MAX)
              scout_pe_next = scout_pe_next + 5'd1;
            if (section_count_next >= 5'(tfd_pkg::HEADER_LEN)) begin
              section_count_next = '0;
              if (header_store[2] == tfd_pkg::TYPE_BASIC ||
                  header_store[2] == tfd_pkg::TYPE_DATA) begin
                section_next = tfd_pkg::SEC_NAME;
              end else begin
                cand_en[3]                 = 1'b1;
                cand[3].kind               = tfd_pkg::KIND_HDR_REJ;
                cand[3].sync_error_count   = {12'd0, scout_se_next};
                cand[3].parity_error_count = {12'd0, scout_pe_next};
                section_next               = tfd_pkg::SEC_SYNC;
              end
            end
          end
          tfd_pkg::SEC_NAME: begin
            section_count_next = section_count_next + 5'd1;
            if (item.sync_flag && scout_se_next < tfd_pkg::SCOUT_MAX)
              scout_se_next = scout_se_next + 5'd1;
            if (item.parity_flag && !item.sync_flag && scout_pe_next < tfd_pkg::SCOUT_MAX)
              scout_pe_next = scout_pe_next + 5'd1;
            cand_en[4]        = 1'b1;
            cand[4].kind      = tfd_pkg::KIND_NAME;
            cand[4].data_byte = item.byte_value;
            if (item.byte_value == tfd_pkg::NAME_END) begin
              if (pay_active_next) begin
                cand_en[5]                 = 1'b1;
                cand[5].kind               = tfd_pkg::KIND_TRUNCATED;
                cand[5].count              = 17'(pay_length_next - pay_offset_next);
                if (pay_length_next < pay_offset_next) cand[5].count = '0;
                cand[5].sync_error_count   = 17'(pay_se_next + cand[5].count);
                cand[5].parity_error_count = 17'(pay_pe_next + cand[5].count);
              end
              cand_en[6]         = 1'b1;
              cand[6].kind       = tfd_pkg::KIND_START;
              cand[6].address    = hdr_start;
              cand[6].count      = file_len;
              cand[6].autorun    = header_store[3] != 8'd0;
              cand[6].basic      = header_store[2] == tfd_pkg::TYPE_BASIC;
              cand[6].file_slow  = item.slow_mode;
              pay_active_next    = 1'b1;
              pay_offset_next    = '0;
              pay_length_next    = file_len;
              pay_start_next     = hdr_start;
              pay_se_next        = {12'd0, scout_se_next};
              pay_pe_next        = {12'd0, scout_pe_next};
              section_next       = tfd_pkg::SEC_SYNC;
              section_count_next = '0;
            end else if (section_count_next >= 5'(tfd_pkg::NAME_CAPACITY)) begin
              cand_en[7]                 = 1'b1;
              cand[7].kind               = tfd_pkg::KIND_NAME_REJ;
              cand[7].sync_error_count   = {12'd0, scout_se_next};
              cand[7].parity_error_count = {12'd0, scout_pe_next};
              section_next               = tfd_pkg::SEC_SYNC;
              section_count_next         = '0;
            end
          end
          default: begin
            section_next = tfd_pkg::SEC_SYNC;
            if (item.byte_value == tfd_pkg::SYNC_BYTE) begin
              if (section_count_next < tfd_pkg::SEC_COUNT_MAX)
                section_count_next = section_count_next + 5'd1;
            end else if (item.byte_value == tfd_pkg::SYNC_END &&
                         section_count_next >= cfg.min_sync_run) begin
              section_next       = tfd_pkg::SEC_HEADER;
              section_count_next = '0;
              scout_se_next      = '0;
              scout_pe_next      = '0;
            end else if (section_count_next >= cfg.min_sync_run && !pay_active_next &&
                         (stray_run_next < cfg.stray_run_limit ||
                          bad_run_next < cfg.bad_run_limit)) begin
              if (section_count_next < tfd_pkg::SEC_COUNT_MAX)
                section_count_next = section_count_next + 5'd1;
            end else begin
              section_count_next = '0;
            end
          end
        endcase
      end
    end
  end

  // pack the enabled results in order
  always_comb begin
    res_n = '0;
    for (int j = 0; j < tfd_pkg::MAX_RESULTS; j++) begin
      res[j] = '0;
    end
    for (int i = 0; i < tfd_pkg::NUM_CAND; i++) begin
      if (cand_en[i] && res_n < tfd_pkg::RES_CNT_W'(tfd_pkg::MAX_RESULTS)) begin
        res[res_n[tfd_pkg::RES_IDX_W-1:0]] = cand[i];
        res_n = res_n + 1'b1;
      end
    end
  end

  assign ctl.load = take;
  assign ctl.n    = res_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      section       <= tfd_pkg::SEC_SYNC;
      section_count <= '0;
      stray_run     <= tfd_pkg::RUN_MAX;
      bad_run       <= tfd_pkg::RUN_MAX;
      mode_slow     <= 1'b0;
      scout_se      <= '0;
      scout_pe      <= '0;
      pay_active    <= 1'b0;
      pay_offset    <= '0;
      pay_length    <= '0;
      pay_start     <= '0;
      pay_se        <= '0;
      pay_pe        <= '0;
    end else begin
      section       <= section_next;
      section_count <= section_count_next;
      stray_run     <= stray_run_next;
      bad_run       <= bad_run_next;
      mode_slow     <= mode_slow_next;
      scout_se      <= scout_se_next;
      scout_pe      <= scout_pe_next;
      pay_active    <= pay_active_next;
      pay_offset    <= pay_offset_next;
      pay_length    <= pay_length_next;
      pay_start     <= pay_start_next;
      pay_se        <= pay_se_next;
      pay_pe        <= pay_pe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      header_store[hdr_wa] <= item.byte_value;
    end
  end

  a_section_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(section))
    else $error("section state lost its one-hot code");

  a_offset_below_length: assert property (@(posedge clk) disable iff (rst)
    pay_active |-> (pay_offset < pay_length))
    else $error("active payload ran past its length");

endmodule

FILE: src/tfd_out_buf.sv
// Result buffer that delivers the results of one item in order.
module tfd_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  tfd_pkg::load_ctl_t  ctl,
  input  tfd_pkg::result_t    res [tfd_pkg::MAX_RESULTS],
  output logic                free,
  output logic                m_valid,
  input  logic                m_ready,
  output tfd_pkg::result_t    m_res,
  output logic                m_last
);

  tfd_pkg::result_t               slots [tfd_pkg::MAX_RESULTS];
  logic [tfd_pkg::RES_CNT_W-1:0]  cnt;
  logic [tfd_pkg::RES_IDX_W-1:0]  rd;
  logic                           taken;

  assign m_valid = cnt != '0;
  assign m_last  = {1'b0, rd} == tfd_pkg::RES_CNT_W'(cnt - 1'b1);
  assign m_res   = slots[rd];
  assign taken   = m_valid && m_ready;
  assign free    = !m_valid || (taken && m_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd  <= '0;
    end else begin
      if (taken) begin
        if (m_last) begin
          cnt <= '0;
          rd  <= '0;
        end else begin
          rd <= rd + 1'b1;
        end
      end
      if (ctl.load) begin
        cnt <= ctl.n;
        rd  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < tfd_pkg::MAX_RESULTS; i++) begin
        slots[i] <= res[i];
      end
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> free)
    else $error("results loaded over undelivered items");

  a_last_then_drain: assert property (@(posedge clk) disable iff (rst)
    (taken && m_last && !ctl.load) |=> !m_valid)
    else $error("buffer still valid after final item taken");

endmodule

FILE: src/tape_file_deframer_unit.sv
// Top level of the tape file deframer: config registers, core and result buffer.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tuser: cmd; s_tdata: byte, slow, sync, parity
//  m_*      out  m_tvalid/m_tready  m_tuser: kind; m_tdata: result fields; m_tlast
//  cfg_*    in   cfg_we             cfg_index, cfg_data
//
// An item is held in the input register and processed into zero to
// four results, which leave one per cycle from the result buffer while
// m_tready is high. The next item is processed once the result buffer is free.
// Reset clears the state and restores the config defaults at once.
// The input register takes the next item while results wait on m_tready.
module tape_file_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // byte_value, slow_mode, sync_flag, parity_flag
  input  logic [0:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // data_byte, address, count, sync_error_count,
                                 // parity_error_count, autorun, basic, file_slow
  output logic [2:0]  m_tuser,   // kind
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  tfd_pkg::cfg_t       cfg;
  tfd_pkg::in_item_t   in_item;
  tfd_pkg::load_ctl_t  ctl;
  tfd_pkg::result_t    res [tfd_pkg::MAX_RESULTS];
  tfd_pkg::result_t    m_res;
  logic                free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_sync_run    <= tfd_pkg::MIN_SYNC_RUN_RST;
      cfg.stray_run_limit <= tfd_pkg::STRAY_RUN_LIMIT_RST;
      cfg.bad_run_limit   <= tfd_pkg::BAD_RUN_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tfd_pkg::CFG_MIN_SYNC_RUN:    cfg.min_sync_run    <= cfg_data;
        tfd_pkg::CFG_STRAY_RUN_LIMIT: cfg.stray_run_limit <= cfg_data[3:0];
        tfd_pkg::CFG_BAD_RUN_LIMIT:   cfg.bad_run_limit   <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  assign in_item.cmd         = s_tuser[0];
  assign in_item.byte_value  = s_tdata[7:0];
  assign in_item.slow_mode   = s_tdata[8];
  assign in_item.sync_flag   = s_tdata[9];
  assign in_item.parity_flag = s_tdata[10];

  tfd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .out_free (free),
    .ctl      (ctl),
    .res      (res)
  );

  tfd_out_buf u_out (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .res     (res),
    .free    (free),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_res   (m_res),
    .m_last  (m_tlast)
  );

  assign m_tuser = m_res.kind;
  assign m_tdata = {2'b00, m_res.file_slow, m_res.basic, m_res.autorun,
                    m_res.parity_error_count, m_res.sync_error_count,
                    m_res.count, m_res.address, m_res.data_byte};

endmodule
